FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while the active-low reset is low.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int SPLIT_SLACK_DEF  = 64;
    localparam logic [31:0] HEAP_BASE_RST  = 32'h0020_0000;
    localparam logic [28:0] HEAP_BYTES_RST = 29'h040_0000;
    localparam logic [28:0] HEAP_BYTES_MAX = 29'h1000_0000;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_RESIZE = 2'd2,
        ACT_REPORT = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOTHING = 3'd1,
        ST_NOMEM   = 3'd2,
        ST_INVALID = 3'd3,
        ST_DOUBLE  = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REG_HEAP_BASE  = 1'b0,
        REG_HEAP_BYTES = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_FIT,
        S_ALLOC,
        S_SHIFT_UP,
        S_FIND_OLD,
        S_RELEASE,
        S_MERGE,
        S_SHIFT_DN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [28:0] request_size;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_address;
        logic [28:0] block_bytes;
        logic [28:0] used_bytes;
        logic [28:0] free_bytes;
    } t_rsp;

    typedef struct packed {
        logic [27:0] offset;
        logic [28:0] size;
        logic        free;
    } t_entry;
endpackage
`default_nettype wire

FILE: design/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with split and coalescing over a block table.
// ----------------------------------------------------------------------------
// Usage: a request (allocate, free, resize or report) is presented on i_req
// with i_start high while o_busy is low. The block then walks its block table,
// which sits in a RAM, entry by entry under a small sequencer,
// and finally pulses o_done for one cycle with the response on o_rsp. The
// receiver cannot stall; the response must be taken in that cycle.
// Report and the trivial cases finish without touching the table. A search
// visits entries in order, a split shifts the tail of the table up, the merge
// pass after a release checks neighbouring pairs in turn, and each merge
// shifts the tail down. The worst case is a resize that moves its block; its
// cost is set by the single RAM read port that every scan and shift goes
// through. One request at a time.
// Reset and a write of heap_bytes collapse the table to a single free entry
// covering the heap; entries beyond the count are never read, so the RAM
// needs no clearing pass. o_busy stays high after reset until that entry is
// written. The user must write heap_base and heap_bytes over the APB port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int SPLIT_SLACK  = SPLIT_SLACK_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_req        i_req,
    output logic             o_busy,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [31:0] SPL = 32'(HEADER_BYTES + SPLIT_SLACK);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    // ---------------- configuration ----------------
    logic [31:0] r_heap_base;
    logic [28:0] r_heap_bytes;
    logic        w_cfg_wr;
    logic [28:0] w_wbytes;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_wbytes = (pwdata[28:0] > HEAP_BYTES_MAX) ? HEAP_BYTES_MAX : pwdata[28:0];
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_HEAP_BYTES) prdata = {3'd0, r_heap_bytes};
        else                            prdata = r_heap_base;
    end

    // ---------------- table RAM ----------------
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata, w_rdata;
    ffha_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_BLOCKS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // ---------------- sequencer state ----------------
    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;           // entry count
    logic [28:0]   r_used, n_used;
    logic [CW-1:0] r_i, n_i;               // scan index
    logic          r_ph, n_ph;             // 0: address issued, 1: data valid
    logic [CW-1:0] r_k, n_k;               // shift index
    t_entry        r_cur, n_cur;           // held entry under work
    logic [1:0]    r_act, n_act;
    logic [31:0]   r_rs, n_rs;             // rounded size
    logic [28:0]   r_req, n_req;
    logic [31:0]   r_addr, n_addr;
    logic          r_resz, n_resz;         // resize pending release of old
    logic [27:0]   r_oldoff, n_oldoff;
    logic [2:0]    r_st, n_st;
    logic [31:0]   r_raddr_o, n_raddr_o;
    logic [28:0]   r_bb, n_bb;
    logic          r_done, n_done;
    logic          r_split, n_split;
    t_entry        r_ins, n_ins;           // entry being inserted by split

    logic [31:0] w_pay;                    // payload address of read entry
    assign w_pay = r_heap_base + {4'd0, w_rdata.offset} + HDR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= CW'(1);
            r_used       <= '0;
            r_done       <= 1'b0;
            r_ph         <= 1'b0;
            r_heap_base  <= HEAP_BASE_RST;
            r_heap_bytes <= HEAP_BYTES_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
            r_done  <= n_done;
            r_ph    <= n_ph;
            if (w_cfg_wr && paddr[2] == REG_HEAP_BASE) r_heap_base <= pwdata;
            if (w_cfg_wr && paddr[2] == REG_HEAP_BYTES) r_heap_bytes <= w_wbytes;
        end
        r_i <= n_i; r_k <= n_k; r_cur <= n_cur; r_act <= n_act;
        r_rs <= n_rs; r_req <= n_req; r_addr <= n_addr; r_resz <= n_resz;
        r_oldoff <= n_oldoff; r_st <= n_st; r_raddr_o <= n_raddr_o; r_bb <= n_bb;
        r_split <= n_split; r_ins <= n_ins;
    end

    // Entry zero is rewritten on reset release and on heap_bytes writes.
    logic r_init, n_init;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init <= 1'b1;
        else          r_init <= n_init;
    end
    logic [28:0] w_hb;
    assign w_hb = (w_cfg_wr && paddr[2] == REG_HEAP_BYTES) ? w_wbytes : r_heap_bytes;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_used = r_used; n_i = r_i; n_ph = r_ph; n_k = r_k;
        n_cur = r_cur; n_act = r_act; n_rs = r_rs; n_req = r_req;
        n_addr = r_addr; n_resz = r_resz; n_oldoff = r_oldoff; n_st = r_st;
        n_raddr_o = r_raddr_o; n_bb = r_bb; n_done = 1'b0; n_split = r_split;
        n_ins = r_ins;
        n_init = 1'b0;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
        if (r_init || (w_cfg_wr && paddr[2] == REG_HEAP_BYTES)) begin
            w_we = 1'b1;
            w_wdata.offset = '0;
            w_wdata.size = (w_hb > HDR[28:0]) ? w_hb - HDR[28:0] : '0;
            w_wdata.free = 1'b1;
            n_cnt  = CW'(1);
            n_used = '0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !r_init) begin
                    n_act = i_req.action; n_req = i_req.request_size;
                    n_addr = i_req.address;
                    n_rs = ({3'd0, i_req.request_size} + 32'd7) & ~32'd7;
                    n_raddr_o = '0; n_bb = '0; n_st = ST_OK; n_resz = 1'b0;
                    n_i = '0; n_ph = 1'b0;
                    priority if (i_req.action == ACT_REPORT) begin
                        n_state = S_DONE;
                    end else if (i_req.action == ACT_ALLOC
                                 || (i_req.action == ACT_RESIZE && i_req.address == '0)) begin
                        if (i_req.request_size == '0) begin
                            n_st = ST_NOTHING; n_state = S_DONE;
                        end else n_state = S_FIT;
                    end else if (i_req.address == '0) begin
                        n_st = ST_NOTHING; n_state = S_DONE;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                // Locate the entry whose payload starts at r_addr.
                w_raddr = r_i[AW-1:0];
                if (!r_ph) begin
                    if (r_i >= r_cnt) begin
                        n_st = ST_INVALID; n_state = S_DONE;
                    end else n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (w_pay == r_addr) begin
                        n_cur = w_rdata;
                        if (r_act == ACT_FREE || r_req == '0) begin
                            // A resize to zero bytes is a free, double free included.
                            if (w_rdata.free) begin
                                n_st = ST_DOUBLE;
                                n_state = S_DONE;
                            end else begin
                                n_bb = w_rdata.size;
                                n_state = S_RELEASE;
                            end
                        end else if (w_rdata.free) begin
                            n_st = ST_INVALID; n_state = S_DONE;
                        end else if (w_rdata.size >= r_req) begin
                            n_raddr_o = r_addr; n_bb = w_rdata.size; n_state = S_DONE;
                        end else begin
                            n_oldoff = w_rdata.offset; n_resz = 1'b1;
                            n_i = '0; n_state = S_FIT;
                        end
                    end else n_i = r_i + CW'(1);
                end
            end
            S_FIT: begin
                // First free entry big enough.
                w_raddr = r_i[AW-1:0];
                if (!r_ph) begin
                    if (r_i >= r_cnt) begin
                        n_st = ST_NOMEM; n_state = S_DONE;
                    end else n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (w_rdata.free && {3'd0, w_rdata.size} >= r_rs) begin
                        n_cur = w_rdata;
                        n_split = ({3'd0, w_rdata.size} >= r_rs + SPL) && (r_cnt < MAXC);
                        n_k = r_cnt;
                        n_state = S_ALLOC;
                    end else n_i = r_i + CW'(1);
                end
            end
            S_ALLOC: begin
                if (r_split) begin
                    n_ins.offset = r_cur.offset + HDR[27:0] + r_rs[27:0];
                    n_ins.size = r_cur.size - r_rs[28:0] - HDR[28:0];
                    n_ins.free = 1'b1;
                    n_cur.size = r_rs[28:0];
                end
                n_state = S_SHIFT_UP;
            end
            S_SHIFT_UP: begin
                // Move entries k-1 -> k down to i+1, then write i and i+1.
                w_raddr = AW'(r_k - CW'(1));
                if (r_split && r_k > r_i + CW'(1)) begin
                    if (!r_ph) n_ph = 1'b1;
                    else begin
                        n_ph = 1'b0;
                        w_we = 1'b1; w_waddr = r_k[AW-1:0]; w_wdata = w_rdata;
                        n_k = r_k - CW'(1);
                    end
                end else if (r_split && !r_ph) begin
                    w_we = 1'b1; w_waddr = AW'(r_i + CW'(1)); w_wdata = r_ins;
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_split) n_cnt = r_cnt + CW'(1);
                    n_cur.free = 1'b0;
                    w_we = 1'b1; w_waddr = r_i[AW-1:0];
                    w_wdata = r_cur; w_wdata.free = 1'b0;
                    n_used = 29'(r_used + r_cur.size + HDR[28:0]);
                    n_raddr_o = r_heap_base + {4'd0, r_cur.offset} + HDR;
                    n_bb = r_cur.size;
                    if (r_resz) begin
                        n_i = '0; n_state = S_FIND_OLD;
                    end else n_state = S_DONE;
                end
            end
            S_FIND_OLD: begin
                w_raddr = r_i[AW-1:0];
                if (!r_ph) n_ph = 1'b1;
                else begin
                    n_ph = 1'b0;
                    if (w_rdata.offset == r_oldoff) begin
                        n_cur = w_rdata; n_state = S_RELEASE;
                    end else n_i = r_i + CW'(1);
                end
            end
            S_RELEASE: begin
                w_we = 1'b1; w_waddr = r_i[AW-1:0];
                w_wdata = r_cur; w_wdata.free = 1'b1;
                n_used = ({3'd0, r_used} >= {3'd0, r_cur.size} + HDR)
                       ? 29'(r_used - r_cur.size - HDR[28:0]) : '0;
                n_i = '0; n_ph = 1'b0; n_k = '0;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                // Walk pairs (i, i+1); r_cur holds entry i once read.
                if (r_i + CW'(1) >= r_cnt) n_state = S_DONE;
                else begin
                    w_raddr = r_ph ? AW'(r_i + CW'(1)) : r_i[AW-1:0];
                    if (!r_ph) n_ph = 1'b1;
                    else if (r_ph && r_k == '0) begin
                        // first beat after issuing i: capture i, issue i+1
                        n_cur = w_rdata; n_k = CW'(1);
                    end else begin
                        n_k = '0; n_ph = 1'b0;
                        if (r_cur.free && w_rdata.free) begin
                            w_we = 1'b1; w_waddr = r_i[AW-1:0]; w_wdata = r_cur;
                            w_wdata.size = 29'(r_cur.size + HDR[28:0] + w_rdata.size);
                            n_k = r_i + CW'(1);
                            n_state = S_SHIFT_DN;
                        end else n_i = r_i + CW'(1);
                    end
                end
            end
            S_SHIFT_DN: begin
                w_raddr = AW'(r_k + CW'(1));
                if (r_k + CW'(1) >= r_cnt) begin
                    n_cnt = r_cnt - CW'(1); n_k = '0; n_ph = 1'b0;
                    n_state = S_MERGE;
                end else if (!r_ph) n_ph = 1'b1;
                else begin
                    n_ph = 1'b0;
                    w_we = 1'b1; w_waddr = r_k[AW-1:0]; w_wdata = w_rdata;
                    n_k = r_k + CW'(1);
                end
            end
            S_DONE: begin
                n_done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_busy = (r_state != S_IDLE) || r_init;
        o_done = r_done;
        o_rsp.status = r_st;
        o_rsp.result_address = r_raddr_o;
        o_rsp.block_bytes = r_bb;
        o_rsp.used_bytes = r_used;
        o_rsp.free_bytes = (r_heap_bytes > r_used) ? r_heap_bytes - r_used : '0;
    end
endmodule
`default_nettype wire

FILE: design/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator command interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ffha_checker
    import ffha_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done,
    input wire t_rsp o_rsp,
    input wire logic pready
);
    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "no busy after start")
    `CHK_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "done longer than one cycle")
    `CHK_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "done while busy")
    `CHK_IMPL(a_status_ok, i_clk, i_rst_n, o_done, o_rsp.status <= ST_DOUBLE, "bad status")
    `CHK_IMPL(a_ready, i_clk, i_rst_n, 1'b1, pready, "pready low")
endmodule
bind first_fit_heap_allocator_core ffha_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_rsp(o_rsp), .pready(pready)
);
`default_nettype wire
